/* design/plist_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plist_pkg
// Types and constants shared by the positional list engine modules.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int CAPACITY = 16;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int POS_W    = 7;
  localparam int VAL_W    = 32;
  localparam int OUTLEN_W = 7;

  // request type codes as seen on the input port
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_DUMP   = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [VAL_W-1:0] item_value;
    logic                    is_last;
    logic [OUTLEN_W-1:0]     list_length;
  } rsp_t;

  // decoded command handed from the front to the back
  typedef struct packed {
    op_e                     op;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

/* design/plist_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plist_front
// Accepts requests, drops unused request types and queues decoded commands.
// ----------------------------------------------------------------------------
module plist_front import plist_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire req_t req_i,
  output logic      cmd_valid_o,
  output cmd_t      cmd_o,
  input  wire logic cmd_pop_i
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept, keep, do_pop;
  cmd_t       cmd_new;

  assign full        = (cnt_q == 2'd2);
  assign accept      = push && !full;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    cmd_new          = '0;
    cmd_new.position = req_i.position;
    cmd_new.value    = req_i.value_in;
    keep             = 1'b1;
    unique case (req_i.req_type)
      REQ_INSERT: cmd_new.op = OP_INSERT;
      REQ_DELETE: cmd_new.op = OP_DELETE;
      REQ_DUMP:   cmd_new.op = OP_DUMP;
      default:    keep = 1'b0;  // unused type: taken and dropped
    endcase
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (accept && keep) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    cnt_d = cnt_q + 2'((accept && keep) ? 1 : 0) - 2'(do_pop ? 1 : 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && keep) begin
      mem_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

/* design/plist_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// plist_back
// Holds the list cells, executes commands and queues the result transactions.
// ----------------------------------------------------------------------------
module plist_back import plist_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      empty,
  input  wire logic pop,
  output rsp_t      rsp_o
);

  logic signed [VAL_W-1:0] cell_q [CAPACITY];
  logic signed [VAL_W-1:0] cell_d [CAPACITY];
  logic [LEN_W-1:0]        len_q, len_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    cell_we;

  rsp_t       oq_q [2];
  logic       owr_q, ord_q;
  logic [1:0] ocnt_q, ocnt_d;
  logic       space, fire, emit, do_pop;
  rsp_t       res;
  logic [POS_W-1:0] len_ext;
  logic             dump_last;

  assign space     = (ocnt_q != 2'd2);
  assign fire      = cmd_valid_i && space;
  assign empty     = (ocnt_q == 2'd0);
  assign rsp_o     = oq_q[ord_q];
  assign do_pop    = pop && !empty;
  assign len_ext   = POS_W'(len_q);
  assign dump_last = ((LEN_W'(idx_q) + LEN_W'(1)) == len_q);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_d[i] = cell_q[i];
    end
    len_d      = len_q;
    idx_d      = idx_q;
    cell_we    = 1'b0;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    res        = '0;
    res.is_last = 1'b1;
    if (fire) begin
      emit = 1'b1;
      unique case (cmd_i.op)
        OP_INSERT: begin
          cmd_pop_o = 1'b1;
          if (cmd_i.position > len_ext) begin
            res.status = ST_BADPOS;
          end else if (len_q == LEN_W'(CAPACITY)) begin
            res.status = ST_FULL;
          end else begin
            res.status = ST_OK;
            cell_we    = 1'b1;
            len_d      = len_q + LEN_W'(1);
            // every cell at or above the position moves up in parallel
            for (int i = 0; i < CAPACITY; i++) begin
              if (POS_W'(i) == cmd_i.position) begin
                cell_d[i] = cmd_i.value;
              end else if ((i > 0) && (POS_W'(i) > cmd_i.position)) begin
                cell_d[i] = cell_q[(i > 0) ? i - 1 : 0];
              end
            end
          end
        end
        OP_DELETE: begin
          cmd_pop_o = 1'b1;
          if (cmd_i.position >= len_ext) begin
            res.status = ST_BADPOS;
          end else begin
            res.status = ST_OK;
            cell_we    = 1'b1;
            len_d      = len_q - LEN_W'(1);
            for (int i = 0; i < CAPACITY - 1; i++) begin
              if (POS_W'(i) >= cmd_i.position) begin
                cell_d[i] = cell_q[i + 1];
              end
            end
          end
        end
        OP_DUMP: begin
          if (len_q == '0) begin
            res.status = ST_EMPTY;
            cmd_pop_o  = 1'b1;
          end else begin
            res.status     = ST_OK;
            res.item_value = cell_q[idx_q];
            res.is_last    = dump_last;
            if (dump_last) begin
              cmd_pop_o = 1'b1;
              idx_d     = '0;
            end else begin
              idx_d = idx_q + IDX_W'(1);
            end
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
          emit      = 1'b0;
        end
      endcase
    end
    res.list_length = OUTLEN_W'(len_d);
  end

  always_comb begin
    ocnt_d = ocnt_q + 2'(emit ? 1 : 0) - 2'(do_pop ? 1 : 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      idx_q  <= '0;
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      len_q  <= len_d;
      idx_q  <= idx_d;
      ocnt_q <= ocnt_d;
      if (emit) begin
        owr_q <= ~owr_q;
      end
      if (do_pop) begin
        ord_q <= ~ord_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_q[i] <= cell_d[i];
      end
    end
    if (emit) begin
      oq_q[owr_q] <= res;
    end
  end

endmodule
`default_nettype wire

/* design/positional_list_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed values with insert, delete and dump requests.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------
//   request   | push / full        | req_i  (req_type, position, value_in)
//   result    | empty / pop        | rsp_o  (status, item_value, is_last,
//             |                    |         list_length)
//
// Insert and delete shift all cells in parallel in the back end. A dump
// returns one result per stored entry (one for an empty list).
// Two-entry queues sit between the request port and the back end and in
// front of the result port, so either side can stall on its own.
// Reset clears the length and all queues; cell contents are not reset.
// ----------------------------------------------------------------------------
module positional_list_engine import plist_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push,
  output logic      full,
  input  wire req_t req_i,
  output logic      empty,
  input  wire logic pop,
  output rsp_t      rsp_o
);

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  plist_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  plist_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire
